// ===== hw/rtl/prrts_pkg.sv =====
// ----------------------------------------------------------------------------
// prrts_pkg: shared types and constants of the thread scheduler
// Slot state and status codes, the ring entry layout and the cell write bus.
// ----------------------------------------------------------------------------
package prrts_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PRIO_W    = 8;
  localparam int SLOT_W    = 4;
  localparam int ACT_W     = 2;

  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FREE  = 2'd1,
    STATUS_DEADLOCK = 2'd2
  } status_e;

  localparam logic MODE_CREATE = 1'b0;
  localparam logic MODE_SCHED  = 1'b1;

  localparam logic [ACT_W-1:0] ACT_KEEP  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_YIELD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EXIT  = 2'd2;

  // One thread slot as it travels around the ring; tag is its slot index.
  typedef struct packed {
    logic [IDX_W-1:0]  tag;
    slot_state_e       state;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast write into the ring, matched by tag in every cell.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  tag;
    slot_state_e       state;
    logic              prio_we;
    logic [PRIO_W-1:0] prio;
  } cell_wr_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

endpackage

// ===== hw/rtl/prrts_req_if.sv =====
// ----------------------------------------------------------------------------
// prrts_req_if: request channel of the thread scheduler
// Valid/ready handshake carrying mode, priority and current-slot action.
// ----------------------------------------------------------------------------
interface prrts_req_if;
  import prrts_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [PRIO_W-1:0] priority_req;
  logic [ACT_W-1:0]  current_action;

  modport source (output valid, mode, priority_req, current_action, input ready);
  modport sink   (input valid, mode, priority_req, current_action, output ready);
endinterface

// ----------------------------------------------------------------------------
// prrts_rsp_if: result channel of the thread scheduler
// Valid/ready handshake carrying slot, switched flag and status.
// ----------------------------------------------------------------------------
interface prrts_rsp_if;
  import prrts_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic              switched;
  logic [1:0]        status;

  modport source (output valid, slot, switched, status, input ready);
  modport sink   (input valid, slot, switched, status, output ready);
endinterface

// ===== hw/rtl/prrts_cell.sv =====
// ----------------------------------------------------------------------------
// prrts_cell: one ring cell of the slot table
// Holds one slot entry, shifts it to the neighbor, takes tag-matched writes.
// ----------------------------------------------------------------------------
module prrts_cell import prrts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] tag_init_i,
  input  logic             shift_i,
  input  entry_t           entry_i,
  input  cell_wr_t         wr_i,
  output entry_t           entry_o
);

  entry_t entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    if (wr_i.en && (entry_q.tag == wr_i.tag)) begin
      entry_d.state = wr_i.state;
      if (wr_i.prio_we) begin
        entry_d.prio = wr_i.prio;
      end
    end else if (shift_i) begin
      entry_d = entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.tag   <= tag_init_i;
      entry_q.state <= SLOT_FREE;
      entry_q.prio  <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/prrts_pick.sv =====
// ----------------------------------------------------------------------------
// prrts_pick: running best-slot tracker at the ring head
// Create: lowest free index. Schedule: lowest priority, then rotation order.
// ----------------------------------------------------------------------------
module prrts_pick import prrts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             step_i,
  input  logic             mode_i,
  input  logic [IDX_W-1:0] cur_i,
  input  entry_t           head_i,
  output pick_t            pick_o
);

  logic              found_d, found_q;
  logic [IDX_W-1:0]  idx_d, idx_q;
  logic [PRIO_W-1:0] prio_d, prio_q;
  logic [IDX_W-1:0]  dist_d, dist_q;

  logic [IDX_W:0]    dist_wide;
  logic [IDX_W-1:0]  cand_dist;
  logic [PRIO_W-1:0] cand_prio;
  logic              cand_ok;
  logic              better;

  always_comb begin
    // distance from one past the current slot, wrapping
    if (head_i.tag > cur_i) begin
      dist_wide = {1'b0, head_i.tag} - {1'b0, cur_i} - (IDX_W+1)'(1);
    end else begin
      dist_wide = {1'b0, head_i.tag} + (IDX_W+1)'(NUM_SLOTS) - {1'b0, cur_i}
                  - (IDX_W+1)'(1);
    end

    if (mode_i == MODE_SCHED) begin
      cand_ok   = (head_i.state == SLOT_RUNNABLE);
      cand_prio = head_i.prio;
      cand_dist = dist_wide[IDX_W-1:0];
    end else begin
      cand_ok   = (head_i.state == SLOT_FREE);
      cand_prio = '0;
      cand_dist = head_i.tag;
    end

    better = cand_ok && (!found_q || ({cand_prio, cand_dist} < {prio_q, dist_q}));

    found_d = found_q;
    idx_d   = idx_q;
    prio_d  = prio_q;
    dist_d  = dist_q;
    if (start_i) begin
      found_d = 1'b0;
    end else if (step_i && better) begin
      found_d = 1'b1;
      idx_d   = head_i.tag;
      prio_d  = cand_prio;
      dist_d  = cand_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    prio_q <= prio_d;
    dist_q <= dist_d;
  end

  assign pick_o.found = found_q;
  assign pick_o.idx   = idx_q;

endmodule

// ===== hw/rtl/priority_round_robin_thread_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// priority_round_robin_thread_scheduler_core: slot table thread scheduler
//
// Requests arrive on req_i (valid/ready): mode 0 creates a thread in the
// lowest free slot with priority_req, mode 1 applies current_action to the
// current slot and picks the runnable slot with the smallest priority,
// ties going to the first slot met after the current one.
// One result per request leaves on rsp_o: slot, switched and status.
// The slot table is a ring of NUM_SLOTS cells that, during a scan, rotates
// one slot per cycle past a head comparator; the action on the current slot
// is applied as it passes the head. A request runs a scan over every slot
// and then a commit step from accept to result, and one request is in
// flight at a time; ready returns the cycle after the commit, so a new
// request is not taken before the last one is committed.
// A new request is taken while a result waits in the output
// register; if the receiver stalls, the following request holds at its
// commit step until the output register is free.
// Reset marks every slot free with priority 0 and sets the current slot
// to 0; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module priority_round_robin_thread_scheduler_core import prrts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  prrts_req_if.sink   req_i,
  prrts_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } fsm_e;

  fsm_e state_d, state_q;

  logic [IDX_W-1:0]  cnt_d, cnt_q;
  logic [IDX_W-1:0]  cur_d, cur_q;
  logic              mode_q;
  logic [PRIO_W-1:0] prio_q;
  logic [ACT_W-1:0]  act_q;

  logic              out_valid_d, out_valid_q;
  logic [SLOT_W-1:0] out_slot_d, out_slot_q;
  logic              out_sw_d, out_sw_q;
  status_e           out_status_d, out_status_q;

  logic     accept;
  logic     shift;
  logic     commit;
  entry_t   ent [NUM_SLOTS];
  entry_t   head_mod;
  cell_wr_t wr;
  pick_t    pick;

  assign accept = req_i.valid && req_i.ready;
  assign shift  = (state_q == S_SCAN);
  assign commit = (state_q == S_COMMIT) && (!out_valid_q || rsp_o.ready);

  // current-slot action applied as that slot passes the head
  always_comb begin
    head_mod = ent[0];
    if (mode_q == MODE_SCHED && ent[0].tag == cur_q) begin
      case (act_q)
        ACT_YIELD: begin
          if (ent[0].state != SLOT_FREE) begin
            head_mod.state = SLOT_RUNNABLE;
          end
        end
        ACT_EXIT: head_mod.state = SLOT_FREE;
        default:  head_mod.state = ent[0].state;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_ring
    entry_t cell_in;
    if (k == NUM_SLOTS - 1) begin : g_wrap
      assign cell_in = head_mod;
    end else begin : g_link
      assign cell_in = ent[k+1];
    end
    prrts_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tag_init_i (IDX_W'(k)),
      .shift_i    (shift),
      .entry_i    (cell_in),
      .wr_i       (wr),
      .entry_o    (ent[k])
    );
  end

  prrts_pick u_pick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .step_i (shift),
    .mode_i (mode_q),
    .cur_i  (cur_q),
    .head_i (head_mod),
    .pick_o (pick)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    out_valid_d  = out_valid_q;
    out_slot_d   = out_slot_q;
    out_sw_d     = out_sw_q;
    out_status_d = out_status_q;
    wr           = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(NUM_SLOTS - 1)) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_d      = S_IDLE;
          out_valid_d  = 1'b1;
          out_sw_d     = 1'b0;
          out_slot_d   = '0;
          out_status_d = STATUS_OK;
          if (mode_q == MODE_CREATE) begin
            if (pick.found) begin
              wr.en      = 1'b1;
              wr.tag     = pick.idx;
              wr.state   = SLOT_RUNNABLE;
              wr.prio_we = 1'b1;
              wr.prio    = prio_q;
              out_slot_d = SLOT_W'(pick.idx);
            end else begin
              out_status_d = STATUS_NO_FREE;
            end
          end else begin
            if (!pick.found) begin
              out_status_d = STATUS_DEADLOCK;
            end else begin
              out_slot_d = SLOT_W'(pick.idx);
              if (pick.idx != cur_q) begin
                wr.en    = 1'b1;
                wr.tag   = pick.idx;
                wr.state = SLOT_RUNNING;
                cur_d    = pick.idx;
                out_sw_d = 1'b1;
              end
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= req_i.mode;
      prio_q <= req_i.priority_req;
      act_q  <= req_i.current_action;
    end
    out_slot_q   <= out_slot_d;
    out_sw_q     <= out_sw_d;
    out_status_q <= out_status_d;
  end

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.slot     = out_slot_q;
  assign rsp_o.switched = out_sw_q;
  assign rsp_o.status   = out_status_q;

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN))
    else $error("request accepted without starting a scan");

  a_deadlock_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == STATUS_DEADLOCK) |->
      (rsp_o.slot == '0 && !rsp_o.switched))
    else $error("deadlock result carries a slot or a switch");

  a_switch_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.switched) |-> (rsp_o.slot == SLOT_W'(cur_q)))
    else $error("switched result does not match the current slot");

endmodule

// ===== test/tb_priority_round_robin_thread_scheduler_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_round_robin_thread_scheduler_core: self-checking bench
// Drives create and schedule requests with random gaps, stalls the result
// side at random, and checks every result against a cycle-free slot table
// model kept in the bench.
// ----------------------------------------------------------------------------
module tb_priority_round_robin_thread_scheduler_core;
  import prrts_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1950;

  typedef struct {
    logic              mode;
    logic [PRIO_W-1:0] prio;
    logic [ACT_W-1:0]  action;
    int                gap;
    bit                drain;
  } sched_req_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              switched;
    status_e           status;
  } sched_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  prrts_req_if req_if ();
  prrts_rsp_if rsp_if ();

  priority_round_robin_thread_scheduler_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Bench copy of the slot table
  slot_state_e       tbl_state [NUM_SLOTS];
  logic [PRIO_W-1:0] tbl_prio  [NUM_SLOTS];
  logic [IDX_W-1:0]  tbl_cur;

  sched_req_t request_q [$];
  sched_rsp_t pending_results [$];

  int cycle_count    = 0;
  int mismatch_count = 0;
  int hold_cnt;
  int stall_cnt;
  int n_create = 0, n_full = 0, n_sched = 0, n_switch = 0, n_deadlock = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 100)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Applies one request to the bench table and returns the result it causes.
  function automatic sched_rsp_t next_sched_result(input logic mode,
                                                   input logic [PRIO_W-1:0] prio,
                                                   input logic [ACT_W-1:0] action);
    sched_rsp_t        res;
    logic              found;
    logic [IDX_W-1:0]  best;
    logic [IDX_W-1:0]  j;
    logic [PRIO_W-1:0] best_p;
    res.slot     = '0;
    res.switched = 1'b0;
    res.status   = STATUS_OK;
    found        = 1'b0;
    best         = '0;
    best_p       = '0;
    if (mode == MODE_CREATE) begin
      n_create++;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!found && tbl_state[i] == SLOT_FREE) begin
          tbl_state[i] = SLOT_RUNNABLE;
          tbl_prio[i]  = prio;
          res.slot     = SLOT_W'(i);
          found        = 1'b1;
        end
      end
      if (!found) begin
        res.status = STATUS_NO_FREE;
        n_full++;
      end
    end else begin
      n_sched++;
      if (action == ACT_YIELD) begin
        if (tbl_state[tbl_cur] != SLOT_FREE) tbl_state[tbl_cur] = SLOT_RUNNABLE;
      end else if (action == ACT_EXIT) begin
        tbl_state[tbl_cur] = SLOT_FREE;
      end
      // rotation starts one past the current slot; strict compare keeps the first tie
      for (int i = 1; i <= NUM_SLOTS; i++) begin
        j = IDX_W'((int'(tbl_cur) + i) % NUM_SLOTS);
        if (tbl_state[j] == SLOT_RUNNABLE && (!found || tbl_prio[j] < best_p)) begin
          found  = 1'b1;
          best   = j;
          best_p = tbl_prio[j];
        end
      end
      if (!found) begin
        res.status = STATUS_DEADLOCK;
        n_deadlock++;
      end else if (best != tbl_cur) begin
        tbl_state[best] = SLOT_RUNNING;
        tbl_cur         = best;
        res.slot        = SLOT_W'(best);
        res.switched    = 1'b1;
        n_switch++;
      end else begin
        res.slot = SLOT_W'(best);
      end
    end
    return res;
  endfunction

  task automatic add_request(input logic mode, input logic [PRIO_W-1:0] prio,
                             input logic [ACT_W-1:0] action, input int gap,
                             input bit drain);
    sched_req_t r;
    r.mode   = mode;
    r.prio   = prio;
    r.action = action;
    r.gap    = gap;
    r.drain  = drain;
    request_q.push_back(r);
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 80) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ACT_W-1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return ACT_KEEP;
    if (r < 65) return ACT_YIELD;
    if (r < 90) return ACT_EXIT;
    return ACT_W'(3);  // unused code, acts as keep
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    bit         took;
    sched_req_t nxt;
    if (!rst_ni) begin
      req_if.valid          <= 1'b0;
      req_if.mode           <= MODE_CREATE;
      req_if.priority_req   <= '0;
      req_if.current_action <= ACT_KEEP;
      hold_cnt              <= 0;
    end else begin
      took = req_if.valid && req_if.ready;
      if (took)
        pending_results.push_back(next_sched_result(req_if.mode, req_if.priority_req,
                                                    req_if.current_action));
      if (!req_if.valid || took) begin
        if (hold_cnt > 0) begin
          hold_cnt     <= hold_cnt - 1;
          req_if.valid <= 1'b0;
        end else if (request_q.size() > 0 && request_q[0].gap > 0) begin
          hold_cnt         <= request_q[0].gap - 1;
          request_q[0].gap  = 0;
          req_if.valid     <= 1'b0;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].drain && pending_results.size() > 0)) begin
          nxt                    = request_q.pop_front();
          req_if.valid          <= 1'b1;
          req_if.mode           <= nxt.mode;
          req_if.priority_req   <= nxt.prio;
          req_if.current_action <= nxt.action;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready generator
  always @(posedge clk_i or negedge rst_ni) begin : sink_proc
    sched_rsp_t want;
    int         r;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_cnt    <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending, slot", rsp_if.slot, 0);
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.slot !== want.slot)
            report_mismatch("slot", rsp_if.slot, want.slot);
          if (rsp_if.switched !== want.switched)
            report_mismatch("switched", rsp_if.switched, want.switched);
          if (rsp_if.status !== want.status)
            report_mismatch("status", rsp_if.status, int'(want.status));
        end
      end
      r = $urandom_range(0, 99);
      if (stall_cnt > 0) begin
        stall_cnt    <= stall_cnt - 1;
        rsp_if.ready <= 1'b0;
      end else if ((cycle_count % 3000) < 400 || r < 85) begin
        rsp_if.ready <= 1'b1;
      end else if (r < 97) begin
        rsp_if.ready <= 1'b0;
        stall_cnt    <= $urandom_range(0, 2);
      end else begin
        rsp_if.ready <= 1'b0;
        stall_cnt    <= $urandom_range(9, 49);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int n;
    int phase_len;
    int create_pct;
    int tie_pct;
    bit calm;
    logic mode;
    logic [PRIO_W-1:0] prio;

    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.mode           = MODE_CREATE;
    req_if.priority_req   = '0;
    req_if.current_action = ACT_KEEP;
    rsp_if.ready          = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_state[i] = SLOT_FREE;
      tbl_prio[i]  = '0;
    end
    tbl_cur = '0;

    // Directed: empty-table schedules, full table, ties, every action
    add_request(MODE_SCHED, 8'h00, ACT_KEEP, 0, 1'b0);   // deadlock from reset
    add_request(MODE_SCHED, 8'hff, ACT_YIELD, 0, 1'b0);  // yield on a free slot
    add_request(MODE_CREATE, 8'hff, ACT_KEEP, 0, 1'b0);
    add_request(MODE_CREATE, 8'h00, ACT_EXIT, 0, 1'b0);
    for (int i = 0; i < NUM_SLOTS - 2; i++)
      add_request(MODE_CREATE, 8'h05, ACT_KEEP, 0, 1'b0);
    add_request(MODE_CREATE, 8'h5a, ACT_KEEP, 0, 1'b0);  // table full
    add_request(MODE_SCHED, 8'ha5, ACT_W'(3), 0, 1'b0);  // unused action
    add_request(MODE_SCHED, 8'h00, ACT_YIELD, 0, 1'b0);  // pick stays on current
    add_request(MODE_SCHED, 8'h00, ACT_EXIT, 0, 1'b0);
    add_request(MODE_SCHED, 8'h00, ACT_KEEP, 0, 1'b0);   // tie after current
    add_request(MODE_CREATE, 8'h80, ACT_KEEP, 0, 1'b0);

    // Random phases with varied create/schedule mix, tie density and pacing
    n = 0;
    while (n < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 160);
      case ($urandom_range(0, 2))
        0:       create_pct = 20;
        1:       create_pct = 50;
        default: create_pct = 80;
      endcase
      tie_pct = $urandom_range(0, 1) ? 70 : 20;
      calm    = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && n < RANDOM_ITEMS; k++) begin
        mode = ($urandom_range(0, 99) < create_pct) ? MODE_CREATE : MODE_SCHED;
        prio = ($urandom_range(0, 99) < tie_pct) ? PRIO_W'($urandom_range(0, 3))
                                                 : PRIO_W'($urandom_range(0, 255));
        add_request(mode, prio, pick_action(), pick_gap(calm),
                    (n == 0) || (n % 400 == 399));
        n++;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (request_q.size() > 0 || req_if.valid) @(posedge clk_i);
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (2 * (NUM_SLOTS + 2)) @(posedge clk_i);

    $display("covered %0d creates (%0d on a full table) and %0d schedules", n_create, n_full,
             n_sched);
    $display("with %0d context switches and %0d deadlocks in %0d cycles", n_switch,
             n_deadlock, cycle_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_count,
               pending_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/prrts_pkg.sv
hw/rtl/prrts_req_if.sv
hw/rtl/prrts_cell.sv
hw/rtl/prrts_pick.sv
hw/rtl/priority_round_robin_thread_scheduler_core.sv
test/tb_priority_round_robin_thread_scheduler_core.sv
